FILE: design/gcoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcoc_pkg;

    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 8;

    localparam int DIM_W   = 11;
    localparam int POS_W   = 16;
    localparam int RAD_W   = 15;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // cell origin in whole pixels, up to 8 cells of 2047
    localparam int COORD_W = 15;
    // signed Q.4 bounds
    localparam int BND_W   = COORD_W + 5;

    localparam logic [DIM_W-1:0] CELL_SIZE_RST     = 11'd64;
    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 11'd512;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 11'd512;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam logic [1:0] REG_CELL_SIZE     = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

endpackage

`default_nettype wire

FILE: design/gcoc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gcoc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [gcoc_pkg::POS_W-1:0]   pos_x;
    logic signed [gcoc_pkg::POS_W-1:0]   pos_y;
    logic        [gcoc_pkg::RAD_W-1:0]   radius;
    logic                                end_of_frame;

    modport source (output valid, pos_x, pos_y, radius, end_of_frame, input ready);
    modport sink   (input valid, pos_x, pos_y, radius, end_of_frame, output ready);
endinterface

`default_nettype wire

FILE: design/gcoc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gcoc_out_if;
    logic                          valid;
    logic                          ready;
    logic [gcoc_pkg::IDX_W-1:0]    cell_row;
    logic [gcoc_pkg::IDX_W-1:0]    cell_col;
    logic [gcoc_pkg::CNT_W-1:0]    occupancy;
    logic                          last_cell;

    modport source (output valid, cell_row, cell_col, occupancy, last_cell, input ready);
    modport sink   (input valid, cell_row, cell_col, occupancy, last_cell, output ready);
endinterface

`default_nettype wire

FILE: design/grid_cell_occupancy_count.sv
`timescale 1ns / 1ps
`default_nettype none

// Uniform grid occupancy counter. Each particle (centre and radius, Q.4 pixels)
// is tested against the active cells one cell per cycle, in raster order, by a
// single bounds compare feeding a read-modify-write of the count store. There
// are at most ROWS*COLS active cells, and ready is low while a particle is in
// progress. A particle flagged end_of_frame is counted first, then every active
// cell is reported in raster order through S_RD_ADDR, S_RD_DATA and S_RD_HOLD;
// the store is then cleared by dropping its per-entry valid bits, so no clearing
// pass follows reset.
// Registers: 0x0 cell_size, 0x4 screen_width, 0x8 screen_height, 11 bits each;
// a cell size of zero acts as one.
module grid_cell_occupancy_count #(
    parameter int ROWS = gcoc_pkg::ROWS_DEF,
    parameter int COLS = gcoc_pkg::COLS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gcoc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [gcoc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [gcoc_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    gcoc_in_if.sink                             particle,
    gcoc_out_if.source                          count
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DW    = gcoc_pkg::DIM_W;
    localparam int XW    = gcoc_pkg::COORD_W;
    localparam int BW    = gcoc_pkg::BND_W;
    localparam int NW    = gcoc_pkg::CNT_W;
    localparam int RDW   = gcoc_pkg::RAD_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_COUNT   = 6'b000010,
        S_DRAIN   = 6'b000100,
        S_RD_ADDR = 6'b001000,
        S_RD_DATA = 6'b010000,
        S_RD_HOLD = 6'b100000
    } state_t;

    // configuration
    logic [DW-1:0] cell_size_reg, screen_width_reg, screen_height_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg     <= gcoc_pkg::CELL_SIZE_RST;
            screen_width_reg  <= gcoc_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= gcoc_pkg::SCREEN_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                gcoc_pkg::REG_CELL_SIZE:     cell_size_reg     <= pwdata[DW-1:0];
                gcoc_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[DW-1:0];
                gcoc_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gcoc_pkg::REG_CELL_SIZE:
                prdata = {{(gcoc_pkg::PDATA_W-DW){1'b0}}, cell_size_reg};
            gcoc_pkg::REG_SCREEN_WIDTH:
                prdata = {{(gcoc_pkg::PDATA_W-DW){1'b0}}, screen_width_reg};
            gcoc_pkg::REG_SCREEN_HEIGHT:
                prdata = {{(gcoc_pkg::PDATA_W-DW){1'b0}}, screen_height_reg};
            default:
                prdata = '0;
        endcase
    end

    // sequencer state
    state_t                 state_reg, state_next;
    logic [RW-1:0]          r_reg, r_next;
    logic [CW-1:0]          c_reg, c_next;
    logic [XW-1:0]          x0_reg, x0_next, y0_reg, y0_next;
    logic signed [BW-1:0]   xp_reg, xp_next, xm_reg, xm_next;
    logic signed [BW-1:0]   yp_reg, yp_next, ym_reg, ym_next;
    logic                   eof_reg, eof_next;
    logic                   hit_d_reg, hit_d_next;
    logic [AW-1:0]          k_d_reg;
    logic [DEPTH-1:0]       vld_reg, vld_next;

    logic                   out_valid_reg, out_valid_next;
    logic [gcoc_pkg::IDX_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [NW-1:0]          occ_reg, occ_next;
    logic                   last_reg, last_next;

    // shared geometry and bounds unit
    logic [XW-1:0]          cs, w_ext, h_ext, x0_end, y0_end, x1, y1;
    logic signed [BW-1:0]   xlo, xhi, ylo, yhi;
    logic                   cell_active, c_last, r_last, hit;
    logic [AW-1:0]          k;
    logic [NW-1:0]          rdata, cur, inc;
    logic                   we;

    assign cs     = (cell_size_reg == '0) ? XW'(1) : XW'(cell_size_reg);
    assign w_ext  = XW'(screen_width_reg);
    assign h_ext  = XW'(screen_height_reg);
    assign x0_end = x0_reg + cs;
    assign y0_end = y0_reg + cs;
    assign x1     = (x0_end > w_ext) ? w_ext : x0_end;
    assign y1     = (y0_end > h_ext) ? h_ext : y0_end;
    assign xlo    = $signed({{(BW-XW-4){1'b0}}, x0_reg, 4'b0});
    assign xhi    = $signed({{(BW-XW-4){1'b0}}, x1, 4'b0});
    assign ylo    = $signed({{(BW-XW-4){1'b0}}, y0_reg, 4'b0});
    assign yhi    = $signed({{(BW-XW-4){1'b0}}, y1, 4'b0});

    assign cell_active = (x0_reg < w_ext) && (y0_reg < h_ext);
    assign c_last      = (c_reg == CW'(COLS - 1)) || (x0_end >= w_ext);
    assign r_last      = (r_reg == RW'(ROWS - 1)) || (y0_end >= h_ext);
    assign hit         = cell_active && (xp_reg > xlo) && (xm_reg < xhi)
                         && (yp_reg > ylo) && (ym_reg < yhi);
    assign k           = AW'(r_reg * COLS + c_reg);

    // count store
    assign we  = hit_d_reg;
    assign cur = vld_reg[k_d_reg] ? rdata : '0;
    assign inc = (cur == gcoc_pkg::CNT_MAX) ? cur : cur + NW'(1);

    gcoc_ram #(
        .WIDTH (NW),
        .DEPTH (DEPTH)
    ) u_counts (
        .clk   (clk),
        .we    (we),
        .waddr (k_d_reg),
        .wdata (inc),
        .raddr (k),
        .rdata (rdata)
    );

    assign particle.ready  = (state_reg == S_IDLE);
    assign count.valid     = out_valid_reg;
    assign count.cell_row  = row_reg;
    assign count.cell_col  = col_reg;
    assign count.occupancy = occ_reg;
    assign count.last_cell = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        xp_next        = xp_reg;
        xm_next        = xm_reg;
        yp_next        = yp_reg;
        ym_next        = ym_reg;
        eof_next       = eof_reg;
        hit_d_next     = 1'b0;
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        occ_next       = occ_reg;
        last_next      = last_reg;

        if (we)
        begin
            vld_next[k_d_reg] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (particle.valid)
                begin
                    xp_next  = BW'(particle.pos_x) + $signed({{(BW-RDW){1'b0}}, particle.radius});
                    xm_next  = BW'(particle.pos_x) - $signed({{(BW-RDW){1'b0}}, particle.radius});
                    yp_next  = BW'(particle.pos_y) + $signed({{(BW-RDW){1'b0}}, particle.radius});
                    ym_next  = BW'(particle.pos_y) - $signed({{(BW-RDW){1'b0}}, particle.radius});
                    eof_next = particle.end_of_frame;
                    r_next   = '0;
                    c_next   = '0;
                    x0_next  = '0;
                    y0_next  = '0;
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                hit_d_next = hit;
                if (!cell_active || (c_last && r_last))
                begin
                    state_next = S_DRAIN;
                end
                else if (c_last)
                begin
                    c_next  = '0;
                    x0_next = '0;
                    r_next  = r_reg + RW'(1);
                    y0_next = y0_end;
                end
                else
                begin
                    c_next  = c_reg + CW'(1);
                    x0_next = x0_end;
                end
            end
            S_DRAIN:
            begin
                r_next  = '0;
                c_next  = '0;
                x0_next = '0;
                y0_next = '0;
                state_next = eof_reg ? S_RD_ADDR : S_IDLE;
            end
            S_RD_ADDR:
            begin
                if (!cell_active)
                begin
                    vld_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD_DATA;
                end
            end
            S_RD_DATA:
            begin
                out_valid_next = 1'b1;
                row_next       = gcoc_pkg::IDX_W'(r_reg);
                col_next       = gcoc_pkg::IDX_W'(c_reg);
                occ_next       = cur;
                last_next      = c_last && r_last;
                state_next     = S_RD_HOLD;
            end
            S_RD_HOLD:
            begin
                if (count.ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        vld_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (c_last)
                        begin
                            c_next  = '0;
                            x0_next = '0;
                            r_next  = r_reg + RW'(1);
                            y0_next = y0_end;
                        end
                        else
                        begin
                            c_next  = c_reg + CW'(1);
                            x0_next = x0_end;
                        end
                        state_next = S_RD_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hit_d_reg     <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            eof_reg       <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            x0_reg        <= '0;
            y0_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_d_reg     <= hit_d_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
            eof_reg       <= eof_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            x0_reg        <= x0_next;
            y0_reg        <= y0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_d_reg <= k;
        xp_reg  <= xp_next;
        xm_reg  <= xm_next;
        yp_reg  <= yp_next;
        ym_reg  <= ym_next;
        row_reg <= row_next;
        col_reg <= col_next;
        occ_reg <= occ_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

FILE: design/gcoc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gcoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: tb/sv/grid_cell_occupancy_count_test.sv
`timescale 1ns / 1ps

typedef struct {
    logic signed [gcoc_pkg::POS_W-1:0] pos_x;
    logic signed [gcoc_pkg::POS_W-1:0] pos_y;
    logic        [gcoc_pkg::RAD_W-1:0] radius;
    logic                              end_of_frame;
} particle_item_t;

typedef struct {
    logic [gcoc_pkg::IDX_W-1:0] cell_row;
    logic [gcoc_pkg::IDX_W-1:0] cell_col;
    logic [gcoc_pkg::CNT_W-1:0] occupancy;
    logic                       last_cell;
} cell_report_t;

class occupancy_tally;
    logic [gcoc_pkg::DIM_W-1:0] cell_size     = gcoc_pkg::CELL_SIZE_RST;
    logic [gcoc_pkg::DIM_W-1:0] screen_width  = gcoc_pkg::SCREEN_WIDTH_RST;
    logic [gcoc_pkg::DIM_W-1:0] screen_height = gcoc_pkg::SCREEN_HEIGHT_RST;
    logic [gcoc_pkg::CNT_W-1:0] counts [gcoc_pkg::ROWS_DEF * gcoc_pkg::COLS_DEF];
    cell_report_t               due_cells [$];
    int errors        = 0;
    int particles     = 0;
    int frames        = 0;
    int cells_checked = 0;

    function new();
        foreach (counts[i])
            counts[i] = '0;
    endfunction

    function int grid_side();
        return (cell_size == '0) ? 1 : int'(cell_size);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            gcoc_pkg::REG_CELL_SIZE:     cell_size     = value[gcoc_pkg::DIM_W-1:0];
            gcoc_pkg::REG_SCREEN_WIDTH:  screen_width  = value[gcoc_pkg::DIM_W-1:0];
            gcoc_pkg::REG_SCREEN_HEIGHT: screen_height = value[gcoc_pkg::DIM_W-1:0];
            default: ;
        endcase
    endfunction

    function void add_particle(particle_item_t item);
        int side;
        int wide;
        int high;
        int rows;
        int cols;
        int px;
        int py;
        int rad;
        int lo;
        int hi;
        int k;
        cell_report_t rep;
        side = grid_side();
        wide = int'(screen_width);
        high = int'(screen_height);
        rows = (high + side - 1) / side;
        cols = (wide + side - 1) / side;
        if (rows > gcoc_pkg::ROWS_DEF)
            rows = gcoc_pkg::ROWS_DEF;
        if (cols > gcoc_pkg::COLS_DEF)
            cols = gcoc_pkg::COLS_DEF;
        px  = item.pos_x;
        py  = item.pos_y;
        rad = int'(item.radius);
        particles++;
        for (int r = 0; r < rows; r++)
        begin
            lo = r * side;
            hi = (r + 1) * side;
            if (hi > high)
                hi = high;
            if (!(py + rad > lo * 16 && py - rad < hi * 16))
                continue;
            for (int c = 0; c < cols; c++)
            begin
                lo = c * side;
                hi = (c + 1) * side;
                if (hi > wide)
                    hi = wide;
                k = r * gcoc_pkg::COLS_DEF + c;
                if (px + rad > lo * 16 && px - rad < hi * 16 && counts[k] != gcoc_pkg::CNT_MAX)
                    counts[k] = counts[k] + 1'b1;
            end
        end
        if (!item.end_of_frame)
            return;
        frames++;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                rep.cell_row  = 3'(r);
                rep.cell_col  = 3'(c);
                rep.occupancy = counts[r * gcoc_pkg::COLS_DEF + c];
                rep.last_cell = (r == rows - 1 && c == cols - 1);
                due_cells.insert(due_cells.size(), rep);
            end
        end
        foreach (counts[i])
            counts[i] = '0;
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_cell(cell_report_t got);
        cell_report_t want;
        cells_checked++;
        if (due_cells.size() == 0)
        begin
            $error("unexpected cell report: row %0d col %0d occupancy %0d",
                   got.cell_row, got.cell_col, got.occupancy);
            errors++;
            return;
        end
        want = due_cells.pop_front();
        compare("cell_row", 16'(want.cell_row), 16'(got.cell_row));
        compare("cell_col", 16'(want.cell_col), 16'(got.cell_col));
        compare("occupancy", want.occupancy, got.occupancy);
        compare("last_cell", 16'(want.last_cell), 16'(got.last_cell));
    endfunction

    function int pending();
        return due_cells.size();
    endfunction
endclass

module grid_cell_occupancy_count_test;
    import gcoc_pkg::*;

    localparam int         RANDOM_ITEMS   = 460;
    localparam int         SETTLE_CYCLES  = 100;
    localparam int         HOLD_CYCLES    = 600;
    localparam int         LIMIT_CYCLES   = 2000000;
    localparam int         IDLE_PERCENT   = 23;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    gcoc_in_if  particle_bus ();
    gcoc_out_if count_bus ();

    grid_cell_occupancy_count dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .particle (particle_bus),
        .count    (count_bus)
    );

    occupancy_tally tally = new();
    bit sender_steady = 1'b0;
    int hold_trigger  = -1;
    int geometries    = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        tally.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // drain the block, then cover the compare pass of an item with no reports
    task automatic settle();
        particle_bus.valid <= 1'b0;
        while (tally.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] side, input logic [DIM_W-1:0] wide,
                                input logic [DIM_W-1:0] high);
        settle();
        write_reg(REG_CELL_SIZE, {21'($urandom), side});
        write_reg(REG_SCREEN_WIDTH, {21'($urandom), wide});
        write_reg(REG_SCREEN_HEIGHT, {21'($urandom), high});
        geometries++;
    endtask

    task automatic offer_particle(input logic signed [POS_W-1:0] px,
                                  input logic signed [POS_W-1:0] py,
                                  input logic [RAD_W-1:0] rad, input logic eof);
        particle_item_t item;
        item.pos_x        = px;
        item.pos_y        = py;
        item.radius       = rad;
        item.end_of_frame = eof;
        while (!sender_steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            particle_bus.valid <= 1'b0;
            @(posedge clk);
        end
        particle_bus.valid        <= 1'b1;
        particle_bus.pos_x        <= px;
        particle_bus.pos_y        <= py;
        particle_bus.radius       <= rad;
        particle_bus.end_of_frame <= eof;
        @(posedge clk);
        while (particle_bus.ready !== 1'b1)
            @(posedge clk);
        tally.add_particle(item);
    endtask

    function automatic logic signed [POS_W-1:0] pick_coord(int extent);
        int side;
        int v;
        side = tally.grid_side();
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 65535) - 32768;
            1, 2:    v = $urandom_range(0, 8) * side * 16 + $urandom_range(0, 32) - 16;
            default: v = $urandom_range(0, extent * 16 + 32) - 16;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[POS_W-1:0];
    endfunction

    function automatic logic [RAD_W-1:0] pick_radius();
        int span;
        span = tally.grid_side() * 12;
        if (span > 32767)
            span = 32767;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 15'($urandom);
            2, 3:    return 15'($urandom_range(0, 16));
            default: return 15'($urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_extent(int side);
        int span;
        span = side * 9;
        if (span > 2047)
            span = 2047;
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 11'd1;
            2:       return 11'h7FF;
            default: return 11'($urandom_range(1, span));
        endcase
    endfunction

    task automatic random_geometry();
        logic [DIM_W-1:0] side;
        int               eff;
        case ($urandom_range(0, 9))
            0:       side = 11'd1;
            1:       side = 11'h7FF;
            2:       side = '0;
            default: side = 11'($urandom_range(4, 300));
        endcase
        eff = (side == '0) ? 1 : int'(side);
        set_geometry(side, pick_extent(eff), pick_extent(eff));
    endtask

    // the readout that holds the stalled report is queued or under way
    function automatic bit hold_due();
        return tally.cells_checked <= hold_trigger
               && tally.cells_checked + tally.pending() >= hold_trigger;
    endfunction

    initial
    begin : cell_sink
        cell_report_t got;
        int           hold_left;
        hold_left = 0;
        count_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && count_bus.valid === 1'b1 && count_bus.ready === 1'b1)
            begin
                got.cell_row  = count_bus.cell_row;
                got.cell_col  = count_bus.cell_col;
                got.occupancy = count_bus.occupancy;
                got.last_cell = count_bus.last_cell;
                tally.check_cell(got);
                if (tally.cells_checked == hold_trigger)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                count_bus.ready <= 1'b0;
            end
            else if (tally.cells_checked >= 150 && tally.cells_checked < 450)
                count_bus.ready <= 1'b1;
            else
                count_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int frame_len;
        rst_n                     <= 1'b0;
        psel                      <= 1'b0;
        penable                   <= 1'b0;
        pwrite                    <= 1'b0;
        paddr                     <= '0;
        pwdata                    <= '0;
        particle_bus.valid        <= 1'b0;
        particle_bus.pos_x        <= '0;
        particle_bus.pos_y        <= '0;
        particle_bus.radius       <= '0;
        particle_bus.end_of_frame <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 8x8 cells of 64 px; strict overlap at edges and corners
        offer_particle(16'd0, 16'd0, 15'd0, 1'b0);
        offer_particle(16'd16, 16'd16, 15'd0, 1'b0);
        offer_particle(16'h8000, 16'h8000, 15'h7FFF, 1'b0);
        offer_particle(16'h7FFF, 16'h7FFF, 15'h7FFF, 1'b0);
        offer_particle(16'd1024, 16'd1024, 15'd0, 1'b0);
        offer_particle(16'd1024, 16'd2048, 15'd1, 1'b0);
        offer_particle(16'd8192, 16'd8191, 15'd16, 1'b1);

        // cell size zero acts as one pixel
        set_geometry('0, 11'd5, 11'd3);
        offer_particle(16'd40, 16'd24, 15'd8, 1'b0);
        offer_particle(16'd80, 16'd48, 15'd0, 1'b1);

        set_geometry(11'd1, 11'h7FF, 11'h7FF);
        offer_particle(16'd64, 16'd64, 15'd40, 1'b0);
        offer_particle(16'd8, 16'd120, 15'd8, 1'b1);

        // single full-screen cell
        set_geometry(11'h7FF, 11'h7FF, 11'h7FF);
        offer_particle(16'h7FFF, 16'h7FFF, 15'd0, 1'b0);
        offer_particle(16'd1600, 16'd1600, 15'd16, 1'b1);

        // geometry change in the middle of a frame
        set_geometry(11'd64, 11'd512, 11'd512);
        offer_particle(16'd100, 16'd100, 15'd0, 1'b0);
        offer_particle(16'd3000, 16'd5000, 15'd2000, 1'b0);
        set_geometry(11'd128, 11'd300, 11'd200);
        offer_particle(16'd4700, 16'd3100, 15'd40, 1'b1);

        // zero extent: no reports, but the readout still clears the counts
        offer_particle(16'd100, 16'd100, 15'd0, 1'b0);
        set_geometry(11'd128, '0, 11'd200);
        offer_particle(16'd100, 16'd100, 15'd16, 1'b1);
        set_geometry(11'd128, 11'd300, '0);
        offer_particle(16'd100, 16'd100, 15'd16, 1'b1);
        settle();
        write_reg(REG_UNUSED, 32'h0000_0005);
        set_geometry(11'h7FF, 11'd1, 11'd1);
        offer_particle(16'd8, 16'd8, 15'd0, 1'b1);

        hold_trigger = tally.cells_checked + 30;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0 && !hold_due())
                random_geometry();
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 20);
            for (int i = 0; i < frame_len; i++)
            begin
                sender_steady = (sent >= 150 && sent < 260);
                if (i > 0 && $urandom_range(0, 15) == 0 && !hold_due())
                    random_geometry();
                offer_particle(pick_coord(int'(tally.screen_width)),
                               pick_coord(int'(tally.screen_height)),
                               pick_radius(), i == frame_len - 1);
                sent++;
            end
        end
        sender_steady = 1'b0;

        settle();
        $display("Sent %0d particles in %0d frames over %0d register settings,", tally.particles,
                 tally.frames, geometries);
        $display("checked %0d cell counts across edge, corner and zero-extent grids",
                 tally.cells_checked);
        if (tally.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
